// ===== design/ps2k_pkg.sv =====
// ps2k_pkg: shared types, codes and scancode tables for the set-1 key decoder
// no dependencies; imported by the decoder, the top level and the checker

package ps2k_pkg;

	// command codes carried in the mode field
	localparam logic [1:0] MODE_SCAN  = 2'd0;
	localparam logic [1:0] MODE_POP   = 2'd1;
	localparam logic [1:0] MODE_FLUSH = 2'd2;

	// special scancode bytes
	localparam logic [7:0] SC_PREFIX_E0 = 8'hE0;
	localparam logic [6:0] SC_LSHIFT    = 7'h2A;
	localparam logic [6:0] SC_RSHIFT    = 7'h36;
	localparam logic [6:0] SC_CTRL      = 7'h1D;
	localparam logic [6:0] SC_ALT       = 7'h38;
	localparam logic [7:0] SC_CAPS      = 8'h3A;
	localparam logic [7:0] SC_F1        = 8'h3B;
	localparam logic [7:0] SC_F10       = 8'h44;
	localparam logic [7:0] SC_F11       = 8'h57;
	localparam logic [7:0] SC_F12       = 8'h58;
	localparam logic [7:0] SC_TABLE_END = 8'd58;

	localparam int unsigned KEY_W = 9;

	// special key numbering
	localparam logic [KEY_W-1:0] NAV_BASE  = 9'd256;
	localparam logic [KEY_W-1:0] FKEY_BASE = 9'd267;
	localparam logic [KEY_W-1:0] KEY_NONE  = 9'd0;

	localparam logic [7:0] CHAR_A_LO = 8'h61;
	localparam logic [7:0] CHAR_Z_LO = 8'h7A;

	typedef struct packed {
		logic shift;
		logic ctrl;
		logic alt;
		logic caps;
		logic ext;
	} ps2k_flags_t;

	// us qwerty, unshifted
	localparam logic [7:0] PLAIN_MAP [58] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
		8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
		8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
		8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
	};

	// us qwerty, shifted
	localparam logic [7:0] SHIFTED_MAP [58] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
		8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
		8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
		8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
	};

	// extended (e0-prefixed) navigation codes
	function automatic logic [KEY_W-1:0] nav_key(input logic [7:0] code);
		logic [KEY_W-1:0] k;
		unique case (code)
			8'h48:   k = NAV_BASE + 9'd0;
			8'h50:   k = NAV_BASE + 9'd1;
			8'h4B:   k = NAV_BASE + 9'd2;
			8'h4D:   k = NAV_BASE + 9'd3;
			8'h47:   k = NAV_BASE + 9'd4;
			8'h4F:   k = NAV_BASE + 9'd5;
			8'h49:   k = NAV_BASE + 9'd6;
			8'h51:   k = NAV_BASE + 9'd7;
			8'h52:   k = NAV_BASE + 9'd8;
			8'h53:   k = NAV_BASE + 9'd9;
			8'h5B:   k = NAV_BASE + 9'd10;
			default: k = KEY_NONE;
		endcase
		return k;
	endfunction

endpackage

// ===== design/ps2k_if.sv =====
// ps2k_cmd_if / ps2k_rsp_if: valid-ready channels of the key decoder
// payload widths follow ps2k_pkg

interface ps2k_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] scan_byte;

	modport source (output valid, output mode, output scan_byte, input ready);
	modport sink   (input valid, input mode, input scan_byte, output ready);
endinterface

interface ps2k_rsp_if;
	logic       valid;
	logic       ready;
	logic [8:0] key;
	logic       key_valid;
	logic       dropped;
	logic       shift_held;
	logic       ctrl_held;
	logic       alt_held;
	logic       caps_on;

	modport source (output valid, output key, output key_valid, output dropped,
		output shift_held, output ctrl_held, output alt_held, output caps_on,
		input ready);
	modport sink   (input valid, input key, input key_valid, input dropped,
		input shift_held, input ctrl_held, input alt_held, input caps_on,
		output ready);
endinterface

// ===== design/ps2k_decode.sv =====
// ps2k_decode: combinational set-1 scancode decode, flags in, flags and key out
// depends on ps2k_pkg

module ps2k_decode (
	input  logic [7:0]           code,
	input  ps2k_pkg::ps2k_flags_t flags,
	output ps2k_pkg::ps2k_flags_t flags_next,
	output logic [8:0]           key,
	output logic                 key_ok
);
	import ps2k_pkg::*;

	logic [6:0] rel;
	logic [7:0] base_chr;
	logic [7:0] shift_chr;
	logic       is_letter;
	logic       use_shifted;

	assign rel       = code[6:0];
	assign base_chr  = PLAIN_MAP[code[5:0] < 6'd58 ? code[5:0] : 6'd0];
	assign shift_chr = SHIFTED_MAP[code[5:0] < 6'd58 ? code[5:0] : 6'd0];
	assign is_letter = (base_chr >= CHAR_A_LO) && (base_chr <= CHAR_Z_LO);
	assign use_shifted = is_letter ? (flags.shift ^ flags.caps) : flags.shift;

	always_comb begin
		flags_next = flags;
		key        = KEY_NONE;
		if (code == SC_PREFIX_E0) begin
			flags_next.ext = 1'b1;
		end else if (code[7]) begin
			// release: drop the matching modifier
			if (rel == SC_LSHIFT || rel == SC_RSHIFT) flags_next.shift = 1'b0;
			if (rel == SC_CTRL) flags_next.ctrl = 1'b0;
			if (rel == SC_ALT) flags_next.alt = 1'b0;
			flags_next.ext = 1'b0;
		end else if (flags.ext) begin
			key            = nav_key(code);
			flags_next.ext = 1'b0;
		end else if (rel == SC_LSHIFT || rel == SC_RSHIFT) begin
			flags_next.shift = 1'b1;
		end else if (rel == SC_CTRL) begin
			flags_next.ctrl = 1'b1;
		end else if (rel == SC_ALT) begin
			flags_next.alt = 1'b1;
		end else if (code == SC_CAPS) begin
			flags_next.caps = ~flags.caps;
		end else if (code >= SC_F1 && code <= SC_F10) begin
			key = FKEY_BASE + {1'b0, 8'(code - SC_F1)};
		end else if (code == SC_F11) begin
			key = FKEY_BASE + 9'd10;
		end else if (code == SC_F12) begin
			key = FKEY_BASE + 9'd11;
		end else if (code < SC_TABLE_END) begin
			key = {1'b0, use_shifted ? shift_chr : base_chr};
		end
	end

	assign key_ok = (key != KEY_NONE);

endmodule

// ===== design/ps2_scancode_to_key_fifo.sv =====
// ps2_scancode_to_key_fifo: set-1 scancode decoder with a ring key queue
// depends on ps2k_pkg, ps2k_if (channels) and ps2k_decode

// Takes one command item per clock unless stalled: a scancode byte, a pop, or a
// flush. Scancode bytes update the shift/ctrl/alt/caps flags and the e0 prefix,
// and a make code that names a key pushes it into a ring queue kept in one
// synchronous memory of FIFO_DEPTH entries; one slot stays empty, so the queue
// holds FIFO_DEPTH-1 keys and a key that finds it full is lost and flagged as
// dropped. Every command gives exactly one response item, via the read and
// response stages, with the flags as they stand after that command. The
// sustained rate is one item per cycle: the memory's single registered read port
// serves the pop and its write port the push, and since one item does one or the
// other, no forwarding is needed. A response stage behind the read stage lets a
// new command enter while a finished response waits. The memory is not cleared
// after reset: only written entries are ever read, so reset is immediate.

module ps2_scancode_to_key_fifo #(
	parameter int FIFO_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	ps2k_cmd_if.sink    cmd,
	ps2k_rsp_if.source  rsp
);
	import ps2k_pkg::*;

	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);

	// key storage: one write port (push), one registered read port (pop)
	logic [KEY_W-1:0] key_store_q [FIFO_DEPTH];

	// queue indices and keyboard flags
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	ps2k_flags_t   flags_q;

	// read stage: command done, memory read in flight
	logic             v_s1;
	logic             key_valid_s1;
	logic             dropped_s1;
	ps2k_flags_t      flags_s1;
	logic [KEY_W-1:0] key_rd_s1;

	// response stage
	logic             v_s2;
	logic [KEY_W-1:0] key_s2;
	logic             key_valid_s2;
	logic             dropped_s2;
	ps2k_flags_t      flags_s2;

	// decoder
	ps2k_flags_t      dec_flags;
	logic [KEY_W-1:0] dec_key;
	logic             dec_key_ok;

	logic          accept;
	logic          adv_s1;
	logic [AW-1:0] head_nxt;
	logic [AW-1:0] tail_nxt;
	logic          q_empty;
	logic          q_full;
	logic          do_push;
	logic          do_pop;

	ps2k_decode u_decode (
		.code       (cmd.scan_byte),
		.flags      (flags_q),
		.flags_next (dec_flags),
		.key        (dec_key),
		.key_ok     (dec_key_ok)
	);

	// pipeline flow: response stage frees up when taken, read stage moves into it
	assign adv_s1    = v_s1 && (!v_s2 || rsp.ready);
	assign cmd.ready = !v_s1 || adv_s1;
	assign accept    = cmd.valid && cmd.ready;

	// ring pointers wrap at any depth, not only powers of two
	assign head_nxt = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
	assign tail_nxt = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
	assign q_empty  = (head_q == tail_q);
	assign q_full   = (head_nxt == tail_q);

	assign do_push = accept && (cmd.mode == MODE_SCAN) && dec_key_ok && !q_full;
	assign do_pop  = accept && (cmd.mode == MODE_POP) && !q_empty;

	// memory ports
	always_ff @(posedge clk) begin
		if (do_push) begin
			key_store_q[head_q] <= dec_key;
		end
		if (do_pop) begin
			key_rd_s1 <= key_store_q[tail_q];
		end
	end

	// command execution: pointers, flags and read-stage status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			flags_q      <= '0;
			v_s1         <= 1'b0;
			key_valid_s1 <= 1'b0;
			dropped_s1   <= 1'b0;
			flags_s1     <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (accept) begin
				key_valid_s1 <= do_pop;
				dropped_s1   <= (cmd.mode == MODE_SCAN) && dec_key_ok && q_full;
				flags_s1     <= (cmd.mode == MODE_SCAN) ? dec_flags : flags_q;
				case (cmd.mode)
					MODE_SCAN: begin
						flags_q <= dec_flags;
						if (dec_key_ok && !q_full) begin
							head_q <= head_nxt;
						end
					end
					MODE_POP: begin
						if (!q_empty) begin
							tail_q <= tail_nxt;
						end
					end
					MODE_FLUSH: begin
						// indices only, flags stay
						head_q <= '0;
						tail_q <= '0;
					end
					default: begin
						// unused code: no change
					end
				endcase
			end
		end
	end

	// response stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s1) begin
			v_s2 <= 1'b1;
		end else if (rsp.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			key_s2       <= key_valid_s1 ? key_rd_s1 : KEY_NONE;
			key_valid_s2 <= key_valid_s1;
			dropped_s2   <= dropped_s1;
			flags_s2     <= flags_s1;
		end
	end

	assign rsp.valid      = v_s2;
	assign rsp.key        = key_s2;
	assign rsp.key_valid  = key_valid_s2;
	assign rsp.dropped    = dropped_s2;
	assign rsp.shift_held = flags_s2.shift;
	assign rsp.ctrl_held  = flags_s2.ctrl;
	assign rsp.alt_held   = flags_s2.alt;
	assign rsp.caps_on    = flags_s2.caps;

endmodule

// ===== design/ps2k_checker.sv =====
// ps2k_checker: port-level checks on the key decoder's response channel
// depends on ps2k_pkg; bound to ps2_scancode_to_key_fifo below

module ps2k_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [8:0] rsp_key,
	input logic       rsp_key_valid,
	input logic       rsp_dropped
);
	import ps2k_pkg::*;

	// a popped key is never the empty code, and no pop means the empty code
	a_key_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_key_valid == (rsp_key != KEY_NONE)))
		else $error("key and key_valid disagree");

	// a pop never loses a key
	a_drop_not_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_dropped) |-> !rsp_key_valid)
		else $error("dropped set on a popped key");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("response valid dropped while stalled");

	a_key_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> $stable(rsp_key))
		else $error("response key changed while stalled");

endmodule

bind ps2_scancode_to_key_fifo ps2k_checker u_ps2k_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_key       (rsp.key),
	.rsp_key_valid (rsp.key_valid),
	.rsp_dropped   (rsp.dropped)
);
